FILE: sv/sobel_edge_magnitude_rgb_core_defines.svh
// Assertion macros shared by the Sobel edge magnitude core.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define SEMR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/semr_pkg.sv
// Types and constants shared by the Sobel edge magnitude core.
package semr_pkg;
	localparam int MaxWidth   = 2048;
	localparam int MaxHeight  = 4096;
	localparam int WidthBits  = 12;
	localparam int HeightBits = 13;
	localparam int ColBits    = $clog2(MaxWidth);
	localparam int RowBits    = HeightBits;
	localparam int PixBits    = 24;
	localparam int GradBits   = 11;
	localparam int SumBits    = 21;
	localparam int RootBits   = 12;
	localparam int RootTopBit = RootBits - 1;
	localparam int BitIdxBits = 4;
	localparam logic [WidthBits-1:0]  WidthReset  = WidthBits'(640);
	localparam logic [HeightBits-1:0] HeightReset = HeightBits'(480);

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_GRAD,
		ST_SQR,
		ST_ROOT,
		ST_RND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                  load;
		logic                  update;
		logic                  grad;
		logic                  square;
		logic                  root_step;
		logic                  round;
		logic                  shifted;
		logic [BitIdxBits-1:0] root_bit;
	} cmd_t;

	typedef struct packed {
		logic emit_a;
		logic emit_b;
	} sts_t;
endpackage

FILE: sv/semr_datapath.sv
// Datapath: line stores, 3x3 window, gradients and iterative rounding square root.
module semr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [semr_pkg::HeightBits-1:0] cfg_wdata,
	input  logic [semr_pkg::PixBits-1:0]  in_data,
	input  logic                          in_filler,
	input  semr_pkg::cmd_t                cmd,
	output semr_pkg::sts_t                sts,
	output logic [semr_pkg::PixBits-1:0]  out_data,
	output logic                          out_last
);
	import semr_pkg::*;

	logic [WidthBits-1:0]  width_q;
	logic [HeightBits-1:0] height_q;
	logic [RowBits-1:0]    row_q;
	logic [ColBits-1:0]    col_q;
	logic [RowBits-1:0]    item_r_s1;
	logic [ColBits-1:0]    item_c_s1;
	logic [PixBits-1:0]    cur_s1;
	logic [PixBits-1:0]    top_rd_q;
	logic [PixBits-1:0]    mid_rd_q;
	logic [PixBits-1:0]    win_q [3][3];
	logic [PixBits-1:0]    top_mem [MaxWidth];
	logic [PixBits-1:0]    mid_mem [MaxWidth];
	logic signed [GradBits-1:0] gx_q [3];
	logic signed [GradBits-1:0] gy_q [3];
	logic signed [GradBits-1:0] gx_d [3];
	logic signed [GradBits-1:0] gy_d [3];
	logic [SumBits-1:0]    s_q [3];
	logic [RootBits-1:0]   n_q [3];
	logic [PixBits-1:0]    out_data_q;
	logic                  out_last_q;

	logic [WidthBits-1:0]  eff_w;
	logic [HeightBits-1:0] eff_h;
	logic                  wrap;
	logic [RowBits-1:0]    pos_r;
	logic [ColBits-1:0]    pos_c;
	logic [PixBits-1:0]    cur_in;
	logic [WidthBits-1:0]  c_inc;
	logic [RowBits:0]      r_inc;
	logic [PixBits-1:0]    new_col [3];

	always_comb begin
		if (width_q == '0) begin
			eff_w = WidthBits'(1);
		end else if (width_q > WidthBits'(MaxWidth)) begin
			eff_w = WidthBits'(MaxWidth);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = HeightBits'(1);
		end else if (height_q > HeightBits'(MaxHeight)) begin
			eff_h = HeightBits'(MaxHeight);
		end else begin
			eff_h = height_q;
		end
	end

	assign wrap   = ({1'b0, col_q} >= eff_w) || (row_q > eff_h);
	assign pos_r  = wrap ? '0 : row_q;
	assign pos_c  = wrap ? '0 : col_q;
	assign cur_in = (pos_r < eff_h && !in_filler) ? in_data : '0;
	assign c_inc  = {1'b0, item_c_s1} + WidthBits'(1);
	assign r_inc  = {1'b0, item_r_s1} + (RowBits+1)'(1);

	assign sts.emit_a = (item_r_s1 != '0) && (item_c_s1 != '0);
	assign sts.emit_b = (item_r_s1 != '0) && ({1'b0, item_c_s1} == eff_w - WidthBits'(1));

	assign new_col[0] = (item_r_s1 >= RowBits'(2)) ? top_rd_q : '0;
	assign new_col[1] = (item_r_s1 != '0) ? mid_rd_q : '0;
	assign new_col[2] = cur_s1;

	// line stores: read at accept, write back on the update cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			top_rd_q  <= top_mem[pos_c];
			mid_rd_q  <= mid_mem[pos_c];
			item_r_s1 <= pos_r;
			item_c_s1 <= pos_c;
			cur_s1    <= cur_in;
		end
		if (cmd.update) begin
			top_mem[item_c_s1] <= mid_rd_q;
			mid_mem[item_c_s1] <= cur_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
			row_q    <= '0;
			col_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (cfg_we) begin
			if (cfg_idx == REG_WIDTH) begin
				width_q <= cfg_wdata[WidthBits-1:0];
			end else begin
				height_q <= cfg_wdata;
			end
			row_q <= '0;
			col_q <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (cmd.update) begin
			if (c_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (r_inc > {1'b0, eff_h}) ? '0 : r_inc[RowBits-1:0];
			end else begin
				col_q <= c_inc[ColBits-1:0];
				row_q <= item_r_s1;
			end
			// a row start sees zeros to its left
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= (item_c_s1 == '0) ? '0 : win_q[i][1];
				win_q[i][1] <= (item_c_s1 == '0) ? '0 : win_q[i][2];
				win_q[i][2] <= new_col[i];
			end
		end
	end

	// Sobel sums per channel; shifted reads one column to the right with zero fill
	always_comb begin
		logic [7:0] px [3][3];
		logic [GradBits-2:0] xp, xn, yp, yn;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (!cmd.shifted) begin
						px[i][j] = win_q[i][j][8*ch +: 8];
					end else if (j == 2) begin
						px[i][j] = '0;
					end else begin
						px[i][j] = win_q[i][j+1][8*ch +: 8];
					end
				end
			end
			xp = {2'b00, px[0][2]} + {1'b0, px[1][2], 1'b0} + {2'b00, px[2][2]};
			xn = {2'b00, px[0][0]} + {1'b0, px[1][0], 1'b0} + {2'b00, px[2][0]};
			yp = {2'b00, px[2][0]} + {1'b0, px[2][1], 1'b0} + {2'b00, px[2][2]};
			yn = {2'b00, px[0][0]} + {1'b0, px[0][1], 1'b0} + {2'b00, px[0][2]};
			gx_d[ch] = $signed({1'b0, xp}) - $signed({1'b0, xn});
			gy_d[ch] = $signed({1'b0, yp}) - $signed({1'b0, yn});
		end
	end

	always_ff @(posedge clk) begin
		logic [2*GradBits-1:0] sqx, sqy;
		logic [RootBits-1:0]   t;
		logic [2*RootBits-1:0] tt, nn;
		logic [RootBits-1:0]   nr;
		for (int ch = 0; ch < 3; ch++) begin
			sqx = gx_q[ch] * gx_q[ch];
			sqy = gy_q[ch] * gy_q[ch];
			t   = n_q[ch] | (RootBits'(1) << cmd.root_bit);
			tt  = t * t;
			nn  = n_q[ch] * (n_q[ch] + RootBits'(1));
			nr  = ({3'b000, s_q[ch]} > nn) ? n_q[ch] + RootBits'(1) : n_q[ch];
			if (cmd.grad) begin
				gx_q[ch] <= gx_d[ch];
				gy_q[ch] <= gy_d[ch];
			end
			if (cmd.square) begin
				s_q[ch] <= sqx[SumBits-1:0] + sqy[SumBits-1:0];
				n_q[ch] <= '0;
			end
			if (cmd.root_step && tt <= {3'b000, s_q[ch]}) begin
				n_q[ch] <= t;
			end
			if (cmd.round) begin
				out_data_q[8*ch +: 8] <= (nr > RootBits'(255)) ? 8'hFF : nr[7:0];
			end
		end
		if (cmd.round) begin
			out_last_q <= cmd.shifted && (item_r_s1 == eff_h);
		end
	end

	assign out_data = out_data_q;
	assign out_last = out_last_q;
endmodule

FILE: sv/semr_ctrl.sv
// Controller: sequences one item through update, gradient, square, root, rounding and output.
module semr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  semr_pkg::sts_t sts,
	output semr_pkg::cmd_t cmd
);
	import semr_pkg::*;
	`include "sobel_edge_magnitude_rgb_core_defines.svh"

	state_t                state_q, state_d;
	logic                  shifted_q, shifted_d;
	logic                  pending_q, pending_d;
	logic [BitIdxBits-1:0] bit_q, bit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			shifted_q <= 1'b0;
			pending_q <= 1'b0;
			bit_q     <= '0;
		end else begin
			state_q   <= state_d;
			shifted_q <= shifted_d;
			pending_q <= pending_d;
			bit_q     <= bit_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		shifted_d    = shifted_q;
		pending_d    = pending_q;
		bit_d        = bit_q;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd          = '0;
		cmd.shifted  = shifted_q;
		cmd.root_bit = bit_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				if (sts.emit_a) begin
					shifted_d = 1'b0;
					pending_d = sts.emit_b;
					state_d   = ST_GRAD;
				end else if (sts.emit_b) begin
					shifted_d = 1'b1;
					pending_d = 1'b0;
					state_d   = ST_GRAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = ST_SQR;
			end
			ST_SQR: begin
				cmd.square = 1'b1;
				bit_d      = BitIdxBits'(RootTopBit);
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				bit_d         = bit_q - BitIdxBits'(1);
				if (bit_q == '0) begin
					state_d = ST_RND;
				end
			end
			ST_RND: begin
				cmd.round = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (pending_q) begin
						shifted_d = 1'b1;
						pending_d = 1'b0;
						state_d   = ST_GRAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`SEMR_ASSERT_NEXT(a_accept_updates, in_valid && in_ready, state_q == ST_UPD, "accepted item not updated")
	`SEMR_ASSERT(a_one_item, !(in_ready && out_valid), "input taken while result pending")
	`SEMR_ASSERT_NEXT(a_second_result, state_q == ST_OUT && out_ready && pending_q, state_q == ST_GRAD && shifted_q, "right edge result lost")
endmodule

FILE: sv/sobel_edge_magnitude_rgb_core.sv
// Sobel 3x3 edge magnitude on an RGB pixel stream: top level.
// Pixels enter in raster order; a frame is image_width x (image_height + 1) items, the last
// row being filler that flushes the final result row. Each color gets round(sqrt(gx^2+gy^2))
// clamped to 255, with pixels outside the frame taken as zero. One item is handled at a time:
// each item is loaded and updated; each result it emits then goes through gradient, square,
// a 12-step shared square root per channel, rounding and output, where it waits out any output
// stall. The line stores are single port memories; no clearing pass after reset.
// Configuration writes restart the frame and are always taken.
module sobel_edge_magnitude_rgb_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_blue, in_green, in_red
	input  logic [0:0]  s_axis_tuser,  // filler
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // out_blue, out_green, out_red
	output logic        m_axis_tlast   // last_of_frame
);
	import semr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	semr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	semr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.in_data   (s_axis_tdata),
		.in_filler (s_axis_tuser[0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);
endmodule
